### design/line_average_deinterlacer_macros.svh
// ----------------------------------------------------------------------------
// line average deinterlacer assertion macros
// shared property shapes for the concurrent checks of the deinterlacer
// ----------------------------------------------------------------------------
`ifndef LINE_AVERAGE_DEINTERLACER_MACROS_SVH
`define LINE_AVERAGE_DEINTERLACER_MACROS_SVH

// condition implies property in the same cycle
`define LAD_ASSERT_SAME(label, clk_s, rst_s, cond, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |-> (prop)) \
        else $error("deinterlacer same-cycle check failed");

// condition implies property in the following cycle
`define LAD_ASSERT_NEXT(label, clk_s, rst_s, cond, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> (prop)) \
        else $error("deinterlacer next-cycle check failed");

`endif

### design/lad_pkg.sv
// ----------------------------------------------------------------------------
// lad_pkg
// types and constants shared by the line average deinterlacer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lad_pkg;

    // parameter defaults
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_PIXEL_BITS = 8;

    // queue between front and back
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

    // fixed field widths
    localparam int LINE_WIDTH_BITS   = 12;
    localparam int FRAME_HEIGHT_BITS = 13;
    localparam int ROW_OUT_BITS      = 12;
    localparam int COL_OUT_BITS      = 11;
    localparam int VALUE_OUT_BITS    = 8;
    localparam int CFG_DATA_BITS     = 13;
    localparam int CFG_INDEX_BITS    = 2;

    // register reset values
    localparam logic [LINE_WIDTH_BITS-1:0]   LINE_WIDTH_RESET   = 12'd720;
    localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

    typedef enum logic [1:0] {
        MODE_LINE_AVG     = 2'd0,
        MODE_PASS         = 2'd1,
        MODE_TOP_FIELD    = 2'd2,
        MODE_BOTTOM_FIELD = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LINE_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_MODE         = 2'd2
    } reg_index_t;

    // what a queued request turns into at the back
    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_STORED = 2'd1,
        KIND_PAIR   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [LINE_WIDTH_BITS-1:0]   line_width;
        logic [FRAME_HEIGHT_BITS-1:0] frame_height;
        mode_t                        mode;
    } cfg_t;

endpackage

### design/lad_ram.sv
// ----------------------------------------------------------------------------
// lad_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on an address collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/lad_fifo.sv
// ----------------------------------------------------------------------------
// lad_fifo
// short register queue that decouples the front from the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lad_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;

    // pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = slot_reg[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

endmodule

### design/lad_front.sv
// ----------------------------------------------------------------------------
// lad_front
// accepts pixels, tracks row and column, classifies each pixel and reads
// and writes the line store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lad_front #(
    parameter int MAX_WIDTH  = lad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lad_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = lad_pkg::DEF_PIXEL_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lad_pkg::cfg_t                         cfg,
    input  logic                                  push,
    output logic                                  full,
    input  logic [PIXEL_BITS-1:0]                 pixel,
    input  logic                                  frame_start,
    input  logic [lad_pkg::QUEUE_LEVEL_BITS-1:0]  q_level,
    output logic                                  q_push,
    output lad_pkg::kind_t                        q_kind,
    output logic [$clog2(MAX_HEIGHT)-1:0]         q_row,
    output logic [$clog2(MAX_WIDTH)-1:0]          q_col,
    output logic [PIXEL_BITS-1:0]                 q_pixel,
    output logic [PIXEL_BITS-1:0]                 q_stored
);

    import lad_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WCMP_W = (LINE_WIDTH_BITS > COL_W + 1) ? LINE_WIDTH_BITS : COL_W + 1;
    localparam int HCMP_W = (FRAME_HEIGHT_BITS > ROW_W + 1) ? FRAME_HEIGHT_BITS : ROW_W + 1;

    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;

    logic                  s1_valid_reg;
    kind_t                 s1_kind_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;

    logic [WCMP_W-1:0]     lw_ext;
    logic [HCMP_W-1:0]     fh_ext;
    logic [COL_W-1:0]      w_last;
    logic [ROW_W-1:0]      h_last;
    logic [COL_W-1:0]      col_base;
    logic [ROW_W-1:0]      row_base;
    logic [COL_W-1:0]      col_cur;
    logic [ROW_W-1:0]      row_cur;
    logic                  even_row;
    logic                  last_row;
    logic                  produce;
    kind_t                 kind;
    logic [ROW_W-1:0]      row_out;
    logic                  accept;
    logic [QUEUE_LEVEL_BITS:0] level_sum;

    // effective line width and frame height, as last index
    always_comb
    begin
        lw_ext = WCMP_W'(cfg.line_width);
        fh_ext = HCMP_W'(cfg.frame_height);
        if (cfg.line_width == '0)
        begin
            w_last = '0;
        end
        else if (lw_ext > WCMP_W'(MAX_WIDTH))
        begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = COL_W'(lw_ext - 1'b1);
        end
        if (fh_ext < HCMP_W'(2))
        begin
            h_last = ROW_W'(1);
        end
        else if (fh_ext > HCMP_W'(MAX_HEIGHT))
        begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = ROW_W'(fh_ext - 1'b1);
        end
    end

    // position of the incoming pixel
    always_comb
    begin
        col_base = frame_start ? '0 : col_reg;
        row_base = frame_start ? '0 : row_reg;
        col_cur  = (col_base > w_last) ? w_last : col_base;
        row_cur  = (row_base > h_last) ? h_last : row_base;
        even_row = !row_cur[0];
        last_row = (row_cur == h_last);
    end

    // classify the pixel by mode
    always_comb
    begin
        produce = 1'b0;
        kind    = KIND_PIXEL;
        row_out = row_cur;
        case (cfg.mode)
            MODE_LINE_AVG:
            begin
                if (even_row)
                begin
                    produce = 1'b1;
                    kind    = (row_cur == '0) ? KIND_PIXEL : KIND_PAIR;
                end
                else if (last_row)
                begin
                    // bottom odd line has no line below: repeat the one above
                    produce = 1'b1;
                    kind    = KIND_STORED;
                end
            end
            MODE_PASS:
            begin
                produce = 1'b1;
            end
            MODE_TOP_FIELD:
            begin
                // an odd frame height leaves the last even line without a partner
                produce = even_row && !last_row;
                row_out = row_cur >> 1;
            end
            MODE_BOTTOM_FIELD:
            begin
                produce = !even_row;
                row_out = row_cur >> 1;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    // room check counts the request still in flight ahead of the queue
    always_comb
    begin
        level_sum = {1'b0, q_level} + {{QUEUE_LEVEL_BITS{1'b0}}, s1_valid_reg};
        full      = (level_sum >= (QUEUE_LEVEL_BITS + 1)'(QUEUE_DEPTH));
        accept    = push && !full;
    end

    // counter advance with wrap at end of line and frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_cur == w_last)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_cur + 1'b1;
            end
            else
            begin
                col_next = col_cur + 1'b1;
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept && produce;
        end
    end

    // request payload, registered together with the line store read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= kind;
            s1_row_reg   <= row_out;
            s1_col_reg   <= col_cur;
            s1_pixel_reg <= pixel;
        end
    end

    // line store holds the last even line
    lad_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (accept && even_row),
        .waddr (col_cur),
        .wdata (pixel),
        .re    (accept),
        .raddr (col_cur),
        .rdata (q_stored)
    );

    assign q_push  = s1_valid_reg;
    assign q_kind  = s1_kind_reg;
    assign q_row   = s1_row_reg;
    assign q_col   = s1_col_reg;
    assign q_pixel = s1_pixel_reg;

endmodule

### design/lad_back.sv
// ----------------------------------------------------------------------------
// lad_back
// turns queued requests into result pixels, one per cycle while requests wait
// and the output slot is free, and holds the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lad_back #(
    parameter int MAX_WIDTH  = lad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lad_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = lad_pkg::DEF_PIXEL_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  lad_pkg::kind_t                      q_kind,
    input  logic [$clog2(MAX_HEIGHT)-1:0]       q_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]        q_col,
    input  logic [PIXEL_BITS-1:0]               q_pixel,
    input  logic [PIXEL_BITS-1:0]               q_stored,
    output logic                                q_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic [lad_pkg::ROW_OUT_BITS-1:0]    out_row,
    output logic [lad_pkg::COL_OUT_BITS-1:0]    out_col,
    output logic [lad_pkg::VALUE_OUT_BITS-1:0]  out_value,
    output logic                                last_of_run
);

    import lad_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  half_reg;
    logic                  half_next;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;
    logic [PIXEL_BITS-1:0] value_reg;
    logic                  last_reg;

    logic                  slot_free;
    logic                  take;
    logic                  first_of_pair;
    logic [PIXEL_BITS:0]   avg_sum;
    logic [PIXEL_BITS-1:0] avg;
    logic [ROW_W-1:0]      row_sel;
    logic [PIXEL_BITS-1:0] value_sel;

    // slot handshake; a pair keeps its request at the queue head until done
    always_comb
    begin
        slot_free      = !out_valid_reg || pop;
        take           = slot_free && !q_empty;
        first_of_pair  = (q_kind == KIND_PAIR) && !half_reg;
        q_pop          = take && !first_of_pair;
        out_valid_next = take ? 1'b1 : (slot_free ? 1'b0 : out_valid_reg);
        half_next      = take ? first_of_pair : half_reg;
    end

    // floor average of the line above and the current pixel
    always_comb
    begin
        avg_sum = {1'b0, q_stored} + {1'b0, q_pixel};
        avg     = avg_sum[PIXEL_BITS:1];
    end

    // result selection
    always_comb
    begin
        row_sel = first_of_pair ? q_row - 1'b1 : q_row;
        case (q_kind)
            KIND_STORED:
            begin
                value_sel = q_stored;
            end
            KIND_PAIR:
            begin
                value_sel = half_reg ? q_pixel : avg;
            end
            default:
            begin
                value_sel = q_pixel;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            row_reg   <= row_sel;
            col_reg   <= q_col;
            value_reg <= value_sel;
            last_reg  <= !first_of_pair;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_row     = ROW_OUT_BITS'(row_reg);
    assign out_col     = COL_OUT_BITS'(col_reg);
    assign out_value   = VALUE_OUT_BITS'(value_reg);
    assign last_of_run = last_reg;

endmodule

### design/line_average_deinterlacer.sv
// path: a taken pixel passes through the front request register, the request
// queue and the output register; the second result of a pair follows the first
// throughput: one pixel per cycle while the four-entry request queue has room;
// the back drives one result per cycle through a single output register while
// results are popped, so even-line pixels past row 0 in line average mode (two results each) are paced by the back
// reset: counters to row 0 column 0, registers to 720 / 480 / line average;
// the line store is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// line_average_deinterlacer
// line average deinterlacer for 8-bit luma with pass-through and field modes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_average_deinterlacer_macros.svh"

module line_average_deinterlacer #(
    parameter int MAX_WIDTH  = lad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lad_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = lad_pkg::DEF_PIXEL_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [PIXEL_BITS-1:0]               pixel,
    input  logic                                frame_start,
    input  logic                                cfg_we,
    input  logic [lad_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lad_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                empty,
    input  logic                                pop,
    output logic [lad_pkg::ROW_OUT_BITS-1:0]    out_row,
    output logic [lad_pkg::COL_OUT_BITS-1:0]    out_col,
    output logic [lad_pkg::VALUE_OUT_BITS-1:0]  out_value,
    output logic                                last_of_run
);

    import lad_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int KIND_W = $bits(kind_t);
    localparam int Q_W    = KIND_W + ROW_W + COL_W + 2 * PIXEL_BITS;

    logic [LINE_WIDTH_BITS-1:0]   line_width_reg;
    logic [FRAME_HEIGHT_BITS-1:0] frame_height_reg;
    mode_t                        mode_reg;
    cfg_t                         cfg;

    logic                         q_push;
    kind_t                        f_kind;
    logic [ROW_W-1:0]             f_row;
    logic [COL_W-1:0]             f_col;
    logic [PIXEL_BITS-1:0]        f_pixel;
    logic [PIXEL_BITS-1:0]        f_stored;
    logic [Q_W-1:0]               q_din;
    logic [Q_W-1:0]               q_dout;
    logic                         q_pop;
    logic                         q_empty;
    logic [QUEUE_LEVEL_BITS-1:0]  q_level;
    logic [KIND_W-1:0]            b_kind_bits;
    logic [ROW_W-1:0]             b_row;
    logic [COL_W-1:0]             b_col;
    logic [PIXEL_BITS-1:0]        b_pixel;
    logic [PIXEL_BITS-1:0]        b_stored;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            mode_reg         <= MODE_LINE_AVG;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_WIDTH:
                begin
                    line_width_reg <= cfg_data[LINE_WIDTH_BITS-1:0];
                end
                REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_data[FRAME_HEIGHT_BITS-1:0];
                end
                REG_MODE:
                begin
                    mode_reg <= mode_t'(cfg_data[1:0]);
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    assign cfg.line_width   = line_width_reg;
    assign cfg.frame_height = frame_height_reg;
    assign cfg.mode         = mode_reg;

    // front: counters, classification, line store
    lad_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .push        (push),
        .full        (full),
        .pixel       (pixel),
        .frame_start (frame_start),
        .q_level     (q_level),
        .q_push      (q_push),
        .q_kind      (f_kind),
        .q_row       (f_row),
        .q_col       (f_col),
        .q_pixel     (f_pixel),
        .q_stored    (f_stored)
    );

    // request queue
    assign q_din = {f_kind, f_row, f_col, f_pixel, f_stored};

    lad_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .level (q_level)
    );

    assign {b_kind_bits, b_row, b_col, b_pixel, b_stored} = q_dout;

    // back: result generation and output register
    lad_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_kind      (kind_t'(b_kind_bits)),
        .q_row       (b_row),
        .q_col       (b_col),
        .q_pixel     (b_pixel),
        .q_stored    (b_stored),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .last_of_run (last_of_run)
    );

    // queue never overflows under the front room check
    `LAD_ASSERT_SAME(a_queue_no_overflow, clk, rst_n, q_push && !q_pop, q_level < QUEUE_LEVEL_BITS'(QUEUE_DEPTH))

    // back never pops an empty queue
    `LAD_ASSERT_SAME(a_queue_no_underflow, clk, rst_n, q_pop, !q_empty)

    // the first result of a pair is always followed by its second
    `LAD_ASSERT_NEXT(a_pair_completes, clk, rst_n, pop && !empty && !last_of_run, !empty && last_of_run)

endmodule
